[design/jsu_pkg.sv]
// Package for the JSON string unescaper: scan modes, result kinds,
// character codes, result word types and the hex digit helper.
// No dependencies.
package jsu_pkg;

    // Scan modes of the decoder
    localparam logic [2:0] MODE_IDLE = 3'd0;
    localparam logic [2:0] MODE_STR  = 3'd1;
    localparam logic [2:0] MODE_ESC  = 3'd2;
    localparam logic [2:0] MODE_HEX1 = 3'd3;
    localparam logic [2:0] MODE_HEX2 = 3'd4;
    localparam logic [2:0] MODE_HEX3 = 3'd5;
    localparam logic [2:0] MODE_HEX4 = 3'd6;
    localparam logic [2:0] MODE_DONE = 3'd7;

    // Result kinds
    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Character codes
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_N = 8'h6E;
    localparam logic [7:0] CH_T = 8'h74;
    localparam logic [7:0] CH_R = 8'h72;
    localparam logic [7:0] CH_U = 8'h75;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_CR = 8'h0D;

    // UTF-8 encoding limits and marks
    localparam logic [15:0] UTF8_ONE_LIMIT = 16'h0080;
    localparam logic [15:0] UTF8_TWO_LIMIT = 16'h0800;
    localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
    localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
    localparam logic [7:0]  UTF8_CONT  = 8'h80;
    localparam logic [7:0]  UTF8_MASK  = 8'h3F;

    localparam int MAX_RESULTS = 3;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
    } t_res;

    // All results caused by one input byte, in order from w[0]
    typedef struct packed {
        t_res [MAX_RESULTS-1:0] w;
        logic [1:0]             cnt;
    } t_burst;

    // Hex digit value: bit 4 is set when the byte is a hex digit
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c inside {[8'h30:8'h39]}) begin
            v = c - 8'h30;
            return {1'b1, v[3:0]};
        end else if (c inside {[8'h61:8'h66]}) begin
            v = c - 8'h57;
            return {1'b1, v[3:0]};
        end else if (c inside {[8'h41:8'h46]}) begin
            v = c - 8'h37;
            return {1'b1, v[3:0]};
        end
        return 5'd0;
    endfunction

endpackage

[design/jsu_if.sv]
// Valid/ready channel interfaces for the JSON string unescaper.
// Depends on jsu_pkg.
interface jsu_in_if import jsu_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       text_ended;

    modport source (output valid, text_byte, text_ended, input ready);
    modport sink   (input valid, text_byte, text_ended, output ready);
endinterface

interface jsu_out_if import jsu_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       run_last;

    modport source (output valid, out_byte, kind, run_last, input ready);
    modport sink   (input valid, out_byte, kind, run_last, output ready);
endinterface

[design/jsu_decode.sv]
// Decoder: scan state registers and the per-byte unescape logic that
// produces up to three result words. Depends on jsu_pkg.
module jsu_decode import jsu_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    input  logic       i_ended,
    output t_burst     o_burst
);

    logic [2:0]  r_mode, n_mode;
    logic [15:0] r_hex, n_hex;
    logic        r_stop, n_stop;
    logic [4:0]  w_digit;
    t_burst      w_burst;

    // Put one result word in slot 0
    function automatic t_burst one_word(input logic [7:0] d, input logic [1:0] k);
        t_burst b;
        b = '0;
        b.w[0].data = d;
        b.w[0].kind = k;
        b.cnt = 2'd1;
        return b;
    endfunction

    // Encode a code point as UTF-8 bytes
    function automatic t_burst utf8(input logic [15:0] cp);
        t_burst b;
        b = '0;
        if (cp < UTF8_ONE_LIMIT) begin
            b.w[0].data = cp[7:0];
            b.cnt = 2'd1;
        end else if (cp < UTF8_TWO_LIMIT) begin
            b.w[0].data = UTF8_LEAD2 | {3'b000, cp[10:6]};
            b.w[1].data = UTF8_CONT | ({2'b00, cp[5:0]} & UTF8_MASK);
            b.cnt = 2'd2;
        end else begin
            b.w[0].data = UTF8_LEAD3 | {4'b0000, cp[15:12]};
            b.w[1].data = UTF8_CONT | ({2'b00, cp[11:6]} & UTF8_MASK);
            b.w[2].data = UTF8_CONT | ({2'b00, cp[5:0]} & UTF8_MASK);
            b.cnt = 2'd3;
        end
        return b;
    endfunction

    assign w_digit = hex_digit(i_byte);

    // Next state and results for the current byte
    always_comb begin
        n_mode  = r_mode;
        n_hex   = r_hex;
        n_stop  = r_stop;
        w_burst = '0;
        if (i_ended) begin
            if (r_mode != MODE_DONE) begin
                w_burst = one_word(8'h00, KIND_ERROR);
            end
            n_mode = MODE_IDLE;
        end else begin
            case (r_mode)
                MODE_IDLE: begin
                    if (i_byte == CH_QUOTE) begin
                        n_mode = MODE_STR;
                    end else begin
                        w_burst = one_word(8'h00, KIND_ERROR);
                        n_mode  = MODE_DONE;
                    end
                end
                MODE_STR: begin
                    if (i_byte == CH_QUOTE) begin
                        w_burst = one_word(8'h00, KIND_CLOSE);
                        n_mode  = MODE_DONE;
                    end else if (i_byte == CH_BSLASH) begin
                        n_mode = MODE_ESC;
                    end else begin
                        w_burst = one_word(i_byte, KIND_BYTE);
                    end
                end
                MODE_ESC: begin
                    n_mode = MODE_STR;
                    case (i_byte)
                        CH_N: w_burst = one_word(CH_LF, KIND_BYTE);
                        CH_T: w_burst = one_word(CH_TAB, KIND_BYTE);
                        CH_R: w_burst = one_word(CH_CR, KIND_BYTE);
                        CH_U: begin
                            n_hex  = 16'h0000;
                            n_stop = 1'b0;
                            n_mode = MODE_HEX1;
                        end
                        default: w_burst = one_word(i_byte, KIND_BYTE);
                    endcase
                end
                MODE_HEX1, MODE_HEX2, MODE_HEX3, MODE_HEX4: begin
                    if (!r_stop && w_digit[4]) begin
                        n_hex = {r_hex[11:0], w_digit[3:0]};
                    end else begin
                        n_stop = 1'b1;
                    end
                    if (r_mode == MODE_HEX4) begin
                        w_burst = utf8(n_hex);
                        n_mode  = MODE_STR;
                    end else begin
                        n_mode = r_mode + 3'd1;
                    end
                end
                default: begin
                    // drop bytes after close or error
                end
            endcase
        end
    end

    // Advance state on each accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_hex  <= 16'h0000;
            r_stop <= 1'b0;
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_hex  <= n_hex;
            r_stop <= n_stop;
        end
    end

    assign o_burst = w_burst;

endmodule

[design/jsu_outq.sv]
// Result queue: holds the up to three words of one byte and hands them
// out one per handshake. Depends on jsu_pkg.
module jsu_outq import jsu_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_load,
    input  t_burst i_burst,
    input  logic   i_pop,
    output logic   o_can_load,
    output logic   o_valid,
    output t_res   o_word,
    output logic   o_last
);

    t_res [MAX_RESULTS-1:0] r_w;
    logic [1:0]             r_cnt;

    assign o_valid    = (r_cnt != 2'd0);
    assign o_word     = r_w[0];
    assign o_last     = (r_cnt == 2'd1);
    assign o_can_load = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && i_pop);

    // Load a fresh burst or shift down on each taken word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_burst.cnt;
        end else if (i_pop && o_valid) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_w <= i_burst.w;
        end else if (i_pop && o_valid) begin
            r_w[0] <= r_w[1];
            r_w[1] <= r_w[2];
        end
    end

endmodule

[design/json_string_unescaper_utf8.sv]
// Top level of the JSON string unescaper with UTF-8 output for \u escapes.
// Depends on jsu_pkg, jsu_if, jsu_decode and jsu_outq.
//
//   channel   dir  word
//   i_text    in   text_byte[7:0], text_ended
//   o_res     out  out_byte[7:0], kind[1:0], run_last
//
// One byte is taken per cycle while the result queue can load. A byte that
// yields several results (up to 3, a three-byte UTF-8 sequence) holds the input
// while the single output port drains the result queue one word a cycle when not stalled.
// Reset is synchronous, active low, and returns the scan to idle.
// A stall on the output holds the queued words; the input waits while more
// than one word is queued, or while the last queued word is stalled.
module json_string_unescaper_utf8 import jsu_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    jsu_in_if.sink    i_text,
    jsu_out_if.source o_res
);

    logic   w_accept;
    logic   w_can_load;
    t_burst w_burst;
    t_res   w_word;
    logic   w_valid;
    logic   w_last;

    assign i_text.ready = w_can_load;
    assign w_accept     = i_text.valid && w_can_load;

    jsu_decode u_dec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(w_accept),
        .i_byte  (i_text.text_byte),
        .i_ended (i_text.text_ended),
        .o_burst (w_burst)
    );

    jsu_outq u_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (w_accept),
        .i_burst   (w_burst),
        .i_pop     (o_res.ready),
        .o_can_load(w_can_load),
        .o_valid   (w_valid),
        .o_word    (w_word),
        .o_last    (w_last)
    );

    // Drive the result channel
    assign o_res.valid    = w_valid;
    assign o_res.out_byte = w_word.data;
    assign o_res.kind     = w_word.kind;
    assign o_res.run_last = w_last;

`ifndef NO_ASSERTIONS
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (w_burst.cnt != 2'd0) |=> o_res.valid)
        else $error("accepted byte with results left no valid word");

    a_marker_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && (o_res.kind != KIND_BYTE) |-> o_res.run_last)
        else $error("close or error word not last of its run");

    a_multi_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (w_burst.cnt > 2'd1) |-> (w_burst.w[0].kind == KIND_BYTE))
        else $error("multi-word burst carries a marker");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.ready && !o_res.run_last |-> !i_text.ready)
        else $error("input taken while several words still queued");
`endif

endmodule

[verif/tb_json_string_unescaper_utf8.sv]
// Testbench for the JSON string unescaper: directed strings, then random well-formed,
// broken and noise text under four idle and stall mixes, checked against a built-in decoder.
// Depends on jsu_pkg, jsu_if and json_string_unescaper_utf8.
`timescale 1ns / 1ps

module tb_json_string_unescaper_utf8;
    import jsu_pkg::*;

    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_DIGIT0  = 8'h30;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_UPPER_G = 8'h47;
    localparam logic [7:0] CH_LOWER_X = 8'h78;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_SEVEN   = 8'h37;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
        logic       run_last;
    } t_dec_word;

    logic i_clk;
    logic i_rst_n;

    jsu_in_if  text_if ();
    jsu_out_if res_if ();

    json_string_unescaper_utf8 DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_text (text_if),
        .o_res  (res_if)
    );

    // Decoder state mirrored from the block
    logic [2:0]  scan_mode;
    logic [15:0] hex_acc;
    logic        hex_halted;

    t_dec_word decoded_q[$];
    int        error_count;
    int        sent_words;
    int        send_idle_pct;
    int        recv_stall_pct;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Hex digit value; bit 4 marks a valid digit
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        if (c >= CH_DIGIT0 && c < CH_DIGIT0 + 8'd10) return {1'b1, 4'(c - CH_DIGIT0)};
        if (c >= CH_LOWER_A && c < CH_LOWER_A + 8'd6) return {1'b1, 4'(c - CH_LOWER_A + 8'd10)};
        if (c >= CH_UPPER_A && c < CH_UPPER_A + 8'd6) return {1'b1, 4'(c - CH_UPPER_A + 8'd10)};
        return 5'd0;
    endfunction

    function automatic void push_decoded(input logic [7:0] data, input logic [1:0] kind);
        t_dec_word w;
        w.data = data;
        w.kind = kind;
        w.run_last = 1'b0;
        decoded_q.push_back(w);
    endfunction

    // Encode a code point as one to three UTF-8 bytes
    function automatic void push_utf8(input logic [15:0] cp);
        if (cp < 16'h0080) begin
            push_decoded(cp[7:0], KIND_BYTE);
        end else if (cp < 16'h0800) begin
            push_decoded(8'hC0 | 8'(cp >> 6), KIND_BYTE);
            push_decoded(8'h80 | 8'(cp & 16'h3F), KIND_BYTE);
        end else begin
            push_decoded(8'hE0 | 8'(cp >> 12), KIND_BYTE);
            push_decoded(8'h80 | 8'((cp >> 6) & 16'h3F), KIND_BYTE);
            push_decoded(8'h80 | 8'(cp & 16'h3F), KIND_BYTE);
        end
    endfunction

    // Advance the decoder by one text word and queue the words it yields
    function automatic void unescape_word(input logic [7:0] c, input logic ended);
        int        before_cnt;
        logic [4:0] nib;
        t_dec_word last_w;
        before_cnt = decoded_q.size();
        if (ended) begin
            if (scan_mode != MODE_DONE) push_decoded(8'h00, KIND_ERROR);
            scan_mode = MODE_IDLE;
        end else begin
            case (scan_mode)
                MODE_IDLE: begin
                    if (c == CH_QUOTE) begin
                        scan_mode = MODE_STR;
                    end else begin
                        push_decoded(8'h00, KIND_ERROR);
                        scan_mode = MODE_DONE;
                    end
                end
                MODE_STR: begin
                    if (c == CH_QUOTE) begin
                        push_decoded(8'h00, KIND_CLOSE);
                        scan_mode = MODE_DONE;
                    end else if (c == CH_BSLASH) begin
                        scan_mode = MODE_ESC;
                    end else begin
                        push_decoded(c, KIND_BYTE);
                    end
                end
                MODE_ESC: begin
                    scan_mode = MODE_STR;
                    case (c)
                        CH_N: push_decoded(CH_LF, KIND_BYTE);
                        CH_T: push_decoded(CH_TAB, KIND_BYTE);
                        CH_R: push_decoded(CH_CR, KIND_BYTE);
                        CH_U: begin
                            hex_acc = 16'h0000;
                            hex_halted = 1'b0;
                            scan_mode = MODE_HEX1;
                        end
                        default: push_decoded(c, KIND_BYTE);
                    endcase
                end
                MODE_HEX1, MODE_HEX2, MODE_HEX3, MODE_HEX4: begin
                    nib = hex_nibble(c);
                    if (!hex_halted && nib[4]) hex_acc = {hex_acc[11:0], nib[3:0]};
                    else hex_halted = 1'b1;
                    if (scan_mode == MODE_HEX4) begin
                        push_utf8(hex_acc);
                        scan_mode = MODE_STR;
                    end else begin
                        scan_mode = scan_mode + 3'd1;
                    end
                end
                default: ;  // drop bytes after close or error
            endcase
        end
        if (decoded_q.size() > before_cnt) begin
            last_w = decoded_q.pop_back();
            last_w.run_last = 1'b1;
            decoded_q.push_back(last_w);
        end
    endfunction

    function automatic void check_word();
        t_dec_word exp_w;
        if (decoded_q.size() == 0) begin
            $error("unexpected word: out_byte %02h kind %0d run_last %0d",
                   res_if.out_byte, res_if.kind, res_if.run_last);
            error_count++;
            return;
        end
        exp_w = decoded_q.pop_front();
        if (res_if.out_byte !== exp_w.data) begin
            $error("out_byte: expected %02h, actual %02h", exp_w.data, res_if.out_byte);
            error_count++;
        end
        if (res_if.kind !== exp_w.kind) begin
            $error("kind: expected %0d, actual %0d", exp_w.kind, res_if.kind);
            error_count++;
        end
        if (res_if.run_last !== exp_w.run_last) begin
            $error("run_last: expected %0d, actual %0d", exp_w.run_last, res_if.run_last);
            error_count++;
        end
    endfunction

    // Predict on accepted text words, then check accepted result words
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (text_if.valid && text_if.ready)
                unescape_word(text_if.text_byte, text_if.text_ended);
            if (res_if.valid && res_if.ready) check_word();
        end
    end

    // Receiver back-pressure
    always @(negedge i_clk) begin
        res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Send one text word, idling at random beforehand
    task automatic send_text(input logic [7:0] b, input logic ended = 1'b0);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            text_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        text_if.valid      <= 1'b1;
        text_if.text_byte  <= b;
        text_if.text_ended <= ended;
        do @(posedge i_clk); while (!(text_if.valid && text_if.ready));
        sent_words++;
    endtask

    task automatic send_end();
        send_text(8'($urandom_range(255)), 1'b1);
    endtask

    // Hold the sender until every queued result has come back
    task automatic drain_results();
        @(negedge i_clk);
        text_if.valid <= 1'b0;
        while (decoded_q.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n, input logic upper);
        if (n < 4'd10) return CH_DIGIT0 + 8'(n);
        return (upper ? CH_UPPER_A : CH_LOWER_A) + 8'(n) - 8'd10;
    endfunction

    task automatic send_unicode_escape();
        logic [15:0] cp;
        logic [7:0]  ch;
        case ($urandom_range(2))
            0: cp = 16'($urandom_range(16'h007F));
            1: cp = 16'($urandom_range(16'h07FF, 16'h0080));
            default: cp = 16'($urandom_range(16'hFFFF, 16'h0800));
        endcase
        send_text(CH_BSLASH);
        send_text(CH_U);
        for (int i = 3; i >= 0; i--) begin
            ch = hex_char(cp[4*i +: 4], 1'($urandom_range(1)));
            if ($urandom_range(9) == 0) ch = 8'($urandom_range(255));
            send_text(ch);
        end
    endtask

    // One piece of string body: plain byte, short escape or \u escape
    task automatic send_string_piece();
        logic [7:0] esc;
        case ($urandom_range(9))
            0, 1, 2, 3: begin
                esc = 8'($urandom_range(255));
                if (esc == CH_QUOTE || esc == CH_BSLASH) esc = CH_LOWER_Z;
                send_text(esc);
            end
            4, 5, 6: begin
                case ($urandom_range(6))
                    0: esc = CH_N;
                    1: esc = CH_T;
                    2: esc = CH_R;
                    3: esc = CH_QUOTE;
                    4: esc = CH_BSLASH;
                    5: esc = CH_SLASH;
                    default: esc = 8'($urandom_range(255));
                endcase
                send_text(CH_BSLASH);
                send_text(esc);
            end
            default: send_unicode_escape();
        endcase
    endtask

    task automatic send_random_text();
        int sel;
        sel = $urandom_range(99);
        if (sel < 80) begin
            // string, mostly closed, sometimes with trailing bytes after the close
            send_text(CH_QUOTE);
            repeat ($urandom_range(8)) send_string_piece();
            if ($urandom_range(9) != 0) begin
                send_text(CH_QUOTE);
                repeat ($urandom_range(2)) send_text(8'($urandom_range(255)));
            end
            send_end();
        end else if (sel < 92) begin
            // text cut off inside the string, an escape or a \u escape
            send_text(CH_QUOTE);
            repeat ($urandom_range(3)) send_string_piece();
            case ($urandom_range(2))
                0: ;
                1: send_text(CH_BSLASH);
                default: begin
                    send_text(CH_BSLASH);
                    send_text(CH_U);
                    repeat ($urandom_range(3))
                        send_text(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
                end
            endcase
            send_end();
        end else begin
            // noise
            repeat ($urandom_range(4, 1))
                send_text(8'($urandom_range(255)), 1'($urandom_range(7) == 0));
            send_end();
        end
    endtask

    // A plain byte, short escapes, a surrogate \u escape, close and a byte after it
    task automatic test_escapes_and_close();
        send_text(CH_QUOTE);
        send_text(8'h00);
        send_text(CH_BSLASH); send_text(CH_T);
        send_text(CH_BSLASH); send_text(CH_R);
        send_text(CH_BSLASH); send_text(CH_N);
        send_text(CH_BSLASH); send_text(CH_U);
        send_text(hex_char(4'hD, 1'b1)); send_text(CH_DIGIT0 + 8'd8);
        send_text(CH_DIGIT0); send_text(CH_DIGIT0);
        send_text(CH_QUOTE);
        send_text(CH_LOWER_Z);
        send_end();
    endtask

    // Missing opening quote, then end of text while idle
    task automatic test_framing_errors();
        send_text(CH_LOWER_X);
        send_end();
        send_end();
    endtask

    // Short hex run that swallows a quote and a backslash, then end after a backslash
    task automatic test_short_hex_run();
        send_text(CH_QUOTE);
        send_text(CH_BSLASH); send_text(CH_U);
        send_text(CH_SEVEN); send_text(CH_QUOTE);
        send_text(CH_BSLASH); send_text(CH_UPPER_G);
        send_text(CH_BSLASH);
        send_end();
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int n_words);
        int start_cnt;
        logic paused;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        start_cnt = sent_words;
        paused = 1'b0;
        while (sent_words - start_cnt < n_words) begin
            send_random_text();
            if (!paused && sent_words - start_cnt >= n_words / 2) begin
                drain_results();
                paused = 1'b1;
            end
        end
        drain_results();
    endtask

    // Run limit
    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        scan_mode          = MODE_IDLE;
        hex_acc            = 16'h0000;
        hex_halted         = 1'b0;
        error_count        = 0;
        sent_words         = 0;
        send_idle_pct      = 0;
        recv_stall_pct     = 0;
        i_rst_n            = 1'b0;
        text_if.valid      = 1'b0;
        text_if.text_byte  = 8'h00;
        text_if.text_ended = 1'b0;
        res_if.ready       = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_escapes_and_close();
        test_framing_errors();
        test_short_hex_run();
        drain_results();

        test_random_traffic(0, 0, 90);
        test_random_traffic(73, 0, 90);
        test_random_traffic(0, 73, 90);
        test_random_traffic(15, 15, 100);

        repeat (20) @(negedge i_clk);
        if (decoded_q.size() != 0) begin
            $error("%0d expected words never arrived", decoded_q.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[sim.f]
design/jsu_pkg.sv
design/jsu_if.sv
design/jsu_decode.sv
design/jsu_outq.sv
design/json_string_unescaper_utf8.sv
verif/tb_json_string_unescaper_utf8.sv
